FILE: hw/rtl/sip_pkg.sv
package sip_pkg;

  // Coordinate word: signed Q12.4. The fraction cancels in the quotient, so only the
  // total width matters to the datapath.
  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;          // a2 - a1 and friends
  localparam int PROD_W = 2 * DIFF_W;           // one 2-D product term
  localparam int CROSS_W = PROD_W + 1;          // difference of two product terms
  localparam int NUM_W = DIFF_W + CROSS_W;      // direction * tn
  localparam int QUO_W = COORD_W;               // |quotient| <= |a2 - a1| < 2^COORD_W

  localparam int GEOM_STAGES = 4;
  localparam int DIV_STAGES = QUO_W;            // one quotient bit per stage
  localparam int NSTAGE = GEOM_STAGES + 1 + DIV_STAGES + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OUT_HIT       = 2'd0,
    OUT_PARALLEL  = 2'd1,
    OUT_T_OUTSIDE = 2'd2,
    OUT_U_OUTSIDE = 2'd3
  } outcome_t;

  // Geometry front end result: numerators for the point and the shared denominator.
  typedef struct packed {
    outcome_t                  outcome;
    logic signed [NUM_W-1:0]   num_x;
    logic signed [NUM_W-1:0]   num_y;
    logic signed [CROSS_W-1:0] den;
    coord_t                    a1_x;
    coord_t                    a1_y;
  } geom_t;

  // One word in flight through the divider, both axes side by side.
  typedef struct packed {
    logic [NUM_W-1:0]   rem_x;
    logic [NUM_W-1:0]   rem_y;
    logic [CROSS_W-1:0] den_mag;
    logic [QUO_W-1:0]   quo_x;
    logic [QUO_W-1:0]   quo_y;
    logic               neg_x;
    logic               neg_y;
    coord_t             a1_x;
    coord_t             a1_y;
    outcome_t           outcome;
  } div_t;

endpackage

FILE: hw/rtl/sip_geom.sv
module sip_geom import sip_pkg::*; (
  input  logic                   clk,
  input  logic [GEOM_STAGES-1:0] en,
  input  coord_t                 a1_x,
  input  coord_t                 a1_y,
  input  coord_t                 a2_x,
  input  coord_t                 a2_y,
  input  coord_t                 b1_x,
  input  coord_t                 b1_y,
  input  coord_t                 b2_x,
  input  coord_t                 b2_y,
  output geom_t                  geom
);

  // num/den in [0,1], exact
  function automatic logic in_unit(input logic signed [CROSS_W-1:0] num,
                                   input logic signed [CROSS_W-1:0] den);
    logic res;
    if (!den[CROSS_W-1]) begin
      res = !num[CROSS_W-1] && (num <= den);
    end else begin
      res = (num[CROSS_W-1] || (num == '0)) && (num >= den);
    end
    return res;
  endfunction

  // stage 1: direction and offset vectors
  logic signed [DIFF_W-1:0] bx1, by1, dx1, dy1, cx1, cy1;
  coord_t a1x1, a1y1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bx1  <= DIFF_W'(a2_x) - DIFF_W'(a1_x);
      by1  <= DIFF_W'(a2_y) - DIFF_W'(a1_y);
      dx1  <= DIFF_W'(b2_x) - DIFF_W'(b1_x);
      dy1  <= DIFF_W'(b2_y) - DIFF_W'(b1_y);
      cx1  <= DIFF_W'(b1_x) - DIFF_W'(a1_x);
      cy1  <= DIFF_W'(b1_y) - DIFF_W'(a1_y);
      a1x1 <= a1_x;
      a1y1 <= a1_y;
    end
  end

  // stage 2: six product terms
  logic signed [PROD_W-1:0] p_bxdy, p_bydx, p_cxdy, p_cydx, p_cxby, p_cybx;
  logic signed [DIFF_W-1:0] bx2, by2;
  coord_t a1x2, a1y2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_bxdy <= bx1 * dy1;
      p_bydx <= by1 * dx1;
      p_cxdy <= cx1 * dy1;
      p_cydx <= cy1 * dx1;
      p_cxby <= cx1 * by1;
      p_cybx <= cy1 * bx1;
      bx2    <= bx1;
      by2    <= by1;
      a1x2   <= a1x1;
      a1y2   <= a1y1;
    end
  end

  // stage 3: cross products
  logic signed [CROSS_W-1:0] den3, tn3, un3;
  logic signed [DIFF_W-1:0] bx3, by3;
  coord_t a1x3, a1y3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      den3 <= CROSS_W'(p_bxdy) - CROSS_W'(p_bydx);
      tn3  <= CROSS_W'(p_cxdy) - CROSS_W'(p_cydx);
      un3  <= CROSS_W'(p_cxby) - CROSS_W'(p_cybx);
      bx3  <= bx2;
      by3  <= by2;
      a1x3 <= a1x2;
      a1y3 <= a1y2;
    end
  end

  // stage 4: classify, and scale direction by tn in parallel
  outcome_t outcome_next;

  always_comb begin
    if (den3 == '0) begin
      outcome_next = OUT_PARALLEL;
    end else if (!in_unit(tn3, den3)) begin
      outcome_next = OUT_T_OUTSIDE;
    end else if (!in_unit(un3, den3)) begin
      outcome_next = OUT_U_OUTSIDE;
    end else begin
      outcome_next = OUT_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      geom.outcome <= outcome_next;
      geom.num_x   <= bx3 * tn3;
      geom.num_y   <= by3 * tn3;
      geom.den     <= den3;
      geom.a1_x    <= a1x3;
      geom.a1_y    <= a1y3;
    end
  end

endmodule

FILE: hw/rtl/sip_div_step.sv
module sip_div_step import sip_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t d_in,
  output div_t d_out
);

  // Restoring step: remainder is shifted up each step, divisor sits at a fixed
  // offset of QUO_W-1 bits.
  logic [NUM_W-1:0] dsh;
  logic             ge_x, ge_y;
  logic [NUM_W-1:0] sub_x, sub_y;

  always_comb begin
    dsh   = NUM_W'({d_in.den_mag, {(QUO_W-1){1'b0}}});
    ge_x  = d_in.rem_x >= dsh;
    ge_y  = d_in.rem_y >= dsh;
    sub_x = ge_x ? (d_in.rem_x - dsh) : d_in.rem_x;
    sub_y = ge_y ? (d_in.rem_y - dsh) : d_in.rem_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem_x   <= sub_x << 1;
      d_out.rem_y   <= sub_y << 1;
      d_out.quo_x   <= {d_in.quo_x[QUO_W-2:0], ge_x};
      d_out.quo_y   <= {d_in.quo_y[QUO_W-2:0], ge_y};
      d_out.den_mag <= d_in.den_mag;
      d_out.neg_x   <= d_in.neg_x;
      d_out.neg_y   <= d_in.neg_y;
      d_out.a1_x    <= d_in.a1_x;
      d_out.a1_y    <= d_in.a1_y;
      d_out.outcome <= d_in.outcome;
    end
  end

endmodule

FILE: hw/rtl/segment_intersection_point.sv
// Segment intersection point. Each input word carries two segments, A (a1 to a2)
// and B (b1 to b2), in signed Q12.4; each output word gives an outcome code (hit,
// parallel, t outside [0,1], u outside [0,1]) and, on a hit, the crossing point
// a1 + (a2 - a1) * t with the quotient truncated toward zero, else a zero point.
// Endpoint contact counts as a hit; a zero-length segment reports parallel.
// The block is a 22-stage pipeline: 4 geometry stages (differences, products,
// cross products, classify and scale), 1 magnitude stage, 16 divider stages that
// each retire one quotient bit for both axes, and 1 output register. One word can
// enter every cycle unless a held output word has backed the pipeline up.
// Backpressure collapses bubbles: a stage takes new data when it is empty or the
// stage after it moves, so input stays ready while empty slots remain even if the
// output word is held.
module segment_intersection_point import sip_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  a1_x,
  input  logic [15:0]  a1_y,
  input  logic [15:0]  a2_x,
  input  logic [15:0]  a2_y,
  input  logic [15:0]  b1_x,
  input  logic [15:0]  b1_y,
  input  logic [15:0]  b2_x,
  input  logic [15:0]  b2_y,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   outcome,
  output logic [15:0]  point_x,
  output logic [15:0]  point_y
);

  // ---------------------------------------------------------------------------
  // Valid chain and per-stage load enables.
  // Stage k loads when it is empty or stage k+1 loads; the last stage drains
  // on out_ready.
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  assign en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;

  for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];

  // ---------------------------------------------------------------------------
  // Geometry front end: stages 0..3
  // ---------------------------------------------------------------------------
  geom_t geom;

  sip_geom u_geom (
    .clk  (clk),
    .en   (en[GEOM_STAGES-1:0]),
    .a1_x (a1_x),
    .a1_y (a1_y),
    .a2_x (a2_x),
    .a2_y (a2_y),
    .b1_x (b1_x),
    .b1_y (b1_y),
    .b2_x (b2_x),
    .b2_y (b2_y),
    .geom (geom)
  );

  // ---------------------------------------------------------------------------
  // Magnitude stage: split numerators and denominator into sign and magnitude
  // for the unsigned divider. Quotient sign is the xor of the operand signs.
  // ---------------------------------------------------------------------------
  div_t div_pipe [DIV_STAGES+1];
  logic [NUM_W-1:0]   mag_x, mag_y;
  logic [CROSS_W-1:0] mag_den;

  always_comb begin
    mag_x   = geom.num_x[NUM_W-1] ? NUM_W'(-geom.num_x) : NUM_W'(geom.num_x);
    mag_y   = geom.num_y[NUM_W-1] ? NUM_W'(-geom.num_y) : NUM_W'(geom.num_y);
    mag_den = geom.den[CROSS_W-1] ? CROSS_W'(-geom.den) : CROSS_W'(geom.den);
  end

  always_ff @(posedge clk) begin
    if (en[GEOM_STAGES]) begin
      div_pipe[0].rem_x   <= mag_x;
      div_pipe[0].rem_y   <= mag_y;
      div_pipe[0].den_mag <= mag_den;
      div_pipe[0].quo_x   <= '0;
      div_pipe[0].quo_y   <= '0;
      div_pipe[0].neg_x   <= geom.num_x[NUM_W-1] ^ geom.den[CROSS_W-1];
      div_pipe[0].neg_y   <= geom.num_y[NUM_W-1] ^ geom.den[CROSS_W-1];
      div_pipe[0].a1_x    <= geom.a1_x;
      div_pipe[0].a1_y    <= geom.a1_y;
      div_pipe[0].outcome <= geom.outcome;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: one quotient bit per stage, MSB first. On a hit |num| < |den|*2^16,
  // so QUO_W steps give the full truncated quotient. On other outcomes the
  // quotient is garbage and is masked at the output.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    sip_div_step u_step (
      .clk   (clk),
      .en    (en[GEOM_STAGES+1+i]),
      .d_in  (div_pipe[i]),
      .d_out (div_pipe[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: restore sign, add a1, zero the point unless hit.
  // Point lies between a1 and a2 on a hit, so a COORD_W-bit add is exact.
  // ---------------------------------------------------------------------------
  div_t     last;
  coord_t   qx, qy;
  coord_t   px_next, py_next;
  outcome_t outcome_q;

  always_comb begin
    last    = div_pipe[DIV_STAGES];
    qx      = last.neg_x ? coord_t'(-last.quo_x) : coord_t'(last.quo_x);
    qy      = last.neg_y ? coord_t'(-last.quo_y) : coord_t'(last.quo_y);
    px_next = '0;
    py_next = '0;
    if (last.outcome == OUT_HIT) begin
      px_next = last.a1_x + qx;
      py_next = last.a1_y + qy;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      outcome_q <= last.outcome;
      point_x   <= px_next;
      point_y   <= py_next;
    end
  end

  assign outcome = outcome_q;

endmodule

FILE: hw/rtl/sip_checker.sv
module sip_checker import sip_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic [15:0]  a1_x,
  input logic [15:0]  a1_y,
  input logic [15:0]  a2_x,
  input logic [15:0]  a2_y,
  input logic [15:0]  b1_x,
  input logic [15:0]  b1_y,
  input logic [15:0]  b2_x,
  input logic [15:0]  b2_y,
  input logic         out_valid,
  input logic         out_ready,
  input logic [1:0]   outcome,
  input logic [15:0]  point_x,
  input logic [15:0]  point_y
);

  // offered input word waits unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(a1_x) && $stable(a1_y)
      && $stable(a2_x) && $stable(a2_y) && $stable(b1_x) && $stable(b1_y)
      && $stable(b2_x) && $stable(b2_y))
    else $error("input word changed while stalled");

  // held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(point_x)
      && $stable(point_y))
    else $error("output word changed while stalled");

  // no point reported unless hit
  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome != OUT_HIT) |-> (point_x == '0) && (point_y == '0))
    else $error("nonzero point on a non-hit outcome");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // an empty output slot means the pipeline can take a word
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (.*);

FILE: bench/segment_intersection_point_tb.sv
// Bench for the segment intersection pipeline.
// A directed table covers hits, parallel pairs, t and u outside [0,1], endpoint
// contact and the coordinate extremes. Random segment pairs follow, most of them
// shaped to cross. Every accepted word is checked in order against a 64-bit
// model of the crossing.
module segment_intersection_point_tb import sip_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ROWS   = 19;
  localparam int RAND_ITEMS = 600;
  localparam int LONG_HOLD  = 120;   // sink hold-off, well over the 22-deep pipe

  // One input word: segment A (a1 to a2) and segment B (b1 to b2).
  typedef struct packed {
    coord_t a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  } seg_pair_t;

  // One output word as the sink should see it.
  typedef struct packed {
    outcome_t code;
    coord_t   px;
    coord_t   py;
  } crossing_t;

  // Directed row; the answer is typed in only where known is set.
  typedef struct packed {
    seg_pair_t seg;
    logic      known;
    outcome_t  code;
    coord_t    px;
    coord_t    py;
  } seg_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  coord_t   a1_x = '0, a1_y = '0, a2_x = '0, a2_y = '0;
  coord_t   b1_x = '0, b1_y = '0, b2_x = '0, b2_y = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic [1:0]  outcome;
  logic [15:0] point_x;
  logic [15:0] point_y;

  crossing_t crossings_due [$];      // predicted words, oldest first
  int  err_count = 0;
  int  checked_count = 0;
  int  sent_count = 0;
  int  backpressure_cycles = 0;
  int  outcome_seen [4] = '{0, 0, 0, 0};
  bit  calm = 1'b0;                  // no random idling on either side while set
  bit  hold_request = 1'b0;          // asks the sink for one long hold-off
  bit  sink_holding = 1'b0;

  segment_intersection_point i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Directed cases. Rows with known = 0 go through the predictor.
  seg_row_t dir_rows [DIR_ROWS] = '{
    // everything at the origin: both segments zero length
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, OUT_PARALLEL, 0, 0},
    // plain cross at the origin
    '{'{-32, 0, 32, 0, 0, -32, 0, 32}, 1'b1, OUT_HIT, 0, 0},
    // parallel, offset lines
    '{'{0, 0, 16, 0, 0, 16, 16, 16}, 1'b1, OUT_PARALLEL, 0, 0},
    // line of B crosses beyond the end of A
    '{'{0, 0, 16, 0, 32, -16, 32, 16}, 1'b1, OUT_T_OUTSIDE, 0, 0},
    // crossing inside A but short of B
    '{'{0, 0, 64, 0, 16, 16, 16, 32}, 1'b1, OUT_U_OUTSIDE, 0, 0},
    // both parameters out: t wins
    '{'{0, 0, 16, 0, 32, 16, 32, 32}, 1'b1, OUT_T_OUTSIDE, 0, 0},
    // B touches the start of A (t = 0)
    '{'{0, 0, 32, 0, 0, -16, 0, 16}, 1'b1, OUT_HIT, 0, 0},
    // B touches the end of A (t = 1)
    '{'{0, 0, 32, 0, 32, -16, 32, 16}, 1'b1, OUT_HIT, 32, 0},
    // B starts on A (u = 0)
    '{'{-16, 0, 16, 0, 0, 0, 0, 16}, 1'b1, OUT_HIT, 0, 0},
    // B ends on A (u = 1)
    '{'{-16, 0, 16, 0, 0, -16, 0, 0}, 1'b1, OUT_HIT, 0, 0},
    // B shrunk to a point
    '{'{16, 16, -48, 80, 5, 5, 5, 5}, 1'b1, OUT_PARALLEL, 0, 0},
    // collinear, overlapping
    '{'{-16, -16, 48, 48, 0, 0, 96, 96}, 1'b1, OUT_PARALLEL, 0, 0},
    // same cross with B reversed: negative cross product
    '{'{-32, 0, 32, 0, 0, 32, 0, -32}, 1'b0, OUT_HIT, 0, 0},
    // full-range diagonals
    '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, 1'b0, OUT_HIT, 0, 0},
    '{'{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}, 1'b0, OUT_HIT, 0, 0},
    // quotient -3.5 must truncate toward zero
    '{'{0, 0, -7, -5, -7, 0, 0, -5}, 1'b0, OUT_HIT, 0, 0},
    // all coordinates at the top of the range, then extreme endpoints
    '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, OUT_HIT, 0, 0},
    '{'{-32768, 32767, 32767, -32768, -1, -1, 0, 0}, 1'b0, OUT_HIT, 0, 0},
    // t outside with a negative cross product
    '{'{0, 0, 16, 0, 32, 16, 32, -16}, 1'b0, OUT_HIT, 0, 0}
  };

  // t = num/den lies in [0,1], either sign of den.
  function automatic bit in_span(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  // Exact crossing in 64 bits; 17-bit differences keep every product exact.
  function automatic crossing_t predict_crossing(seg_pair_t s);
    longint dax, day, dbx, dby, ofx, ofy, den, tn, un;
    crossing_t r;
    dax = $signed(s.a2x) - $signed(s.a1x);
    day = $signed(s.a2y) - $signed(s.a1y);
    dbx = $signed(s.b2x) - $signed(s.b1x);
    dby = $signed(s.b2y) - $signed(s.b1y);
    ofx = $signed(s.b1x) - $signed(s.a1x);
    ofy = $signed(s.b1y) - $signed(s.a1y);
    den = dax * dby - day * dbx;
    tn  = ofx * dby - ofy * dbx;
    un  = ofx * day - ofy * dax;
    r = '{OUT_PARALLEL, '0, '0};
    if (den != 0) begin
      if (!in_span(tn, den)) r.code = OUT_T_OUTSIDE;
      else if (!in_span(un, den)) r.code = OUT_U_OUTSIDE;
      else begin
        // SV division on longint truncates toward zero
        r.code = OUT_HIT;
        r.px = coord_t'($signed(s.a1x) + (dax * tn) / den);
        r.py = coord_t'($signed(s.a1y) + (day * tn) / den);
      end
    end
    return r;
  endfunction

  function automatic int span_rand(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic coord_t corner_val();
    case ($urandom_range(0, 4))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Random pair. Default shape: A and B both pass through (px, py) from
  // opposite sides, so most pairs hit; other shapes bend that on purpose.
  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    int kind, lim, px, py, gx, gy, ex, ey, h, f;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: lim = 8000;
      1: lim = 1000;
      default: lim = 64;
    endcase
    px = span_rand(lim);
    py = span_rand(lim);
    gx = span_rand(lim);
    gy = span_rand(lim);
    ex = span_rand(lim);
    ey = span_rand(lim);
    h = $urandom_range(1, 3);
    f = $urandom_range(1, 3);
    s.a1x = coord_t'(px + gx);
    s.a1y = coord_t'(py + gy);
    s.a2x = coord_t'(px - gx * h);
    s.a2y = coord_t'(py - gy * h);
    s.b1x = coord_t'(px + ex);
    s.b1y = coord_t'(py + ey);
    s.b2x = coord_t'(px - ex * f);
    s.b2y = coord_t'(py - ey * f);
    if (kind < 10) begin
      // B starts exactly on an end of A or on the crossing
      case ($urandom_range(0, 2))
        0: begin s.b1x = s.a1x; s.b1y = s.a1y; end
        1: begin s.b1x = s.a2x; s.b1y = s.a2y; end
        default: begin s.b1x = coord_t'(px); s.b1y = coord_t'(py); end
      endcase
    end else if (kind < 18) begin
      // parallel, collinear or zero length
      case ($urandom_range(0, 2))
        0: begin
          s.b2x = coord_t'(s.b1x + (s.a2x - s.a1x));
          s.b2y = coord_t'(s.b1y + (s.a2y - s.a1y));
        end
        1: begin
          s.b1x = s.a2x;
          s.b1y = s.a2y;
          s.b2x = coord_t'(2 * s.a2x - s.a1x);
          s.b2y = coord_t'(2 * s.a2y - s.a1y);
        end
        default: begin s.b2x = s.b1x; s.b2y = s.b1y; end
      endcase
    end else if (kind < 33) begin
      // near miss: nudge endpoints around the crossing
      s.b1x = coord_t'(s.b1x + span_rand(6));
      s.b2y = coord_t'(s.b2y + span_rand(6));
      s.a2x = coord_t'(s.a2x + span_rand(6));
      s.a1y = coord_t'(s.a1y + span_rand(6));
    end else if (kind < 45) begin
      s = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (kind < 52) begin
      s.a1x = corner_val();
      s.a1y = corner_val();
      s.a2x = corner_val();
      s.a2y = corner_val();
      s.b1x = corner_val();
      s.b1y = corner_val();
      s.b2x = corner_val();
      s.b2y = corner_val();
    end
    return s;
  endfunction

  // Present one pair, hold it until accepted, queue its answer, maybe idle.
  task automatic offer_pair(seg_pair_t s, crossing_t want);
    in_valid <= 1'b1;
    a1_x <= s.a1x;
    a1_y <= s.a1y;
    a2_x <= s.a2x;
    a2_y <= s.a2y;
    b1_x <= s.b1x;
    b1_y <= s.b1y;
    b2_x <= s.b2x;
    b2_y <= s.b2y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    crossings_due.push_back(want);
    sent_count++;
    // keep offering back to back while the sink holds off
    if (!calm && !sink_holding && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic void check_word();
    crossing_t want;
    outcome_seen[outcome]++;
    if (crossings_due.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("unexpected word: outcome %0d point (%0d,%0d)",
                 outcome, $signed(point_x), $signed(point_y));
      return;
    end
    want = crossings_due.pop_front();
    if (outcome !== want.code || point_x !== want.px || point_y !== want.py) begin
      err_count++;
      if (err_count <= 10)
        $display("word %0d: expected %s (%0d,%0d), got outcome %0d (%0d,%0d)",
                 checked_count, want.code.name(), want.px, want.py,
                 outcome, $signed(point_x), $signed(point_y));
    end
    checked_count++;
  endfunction

  // Sink: checks each accepted word, then picks out_ready for the next cycle.
  // A hold request makes it drop ready until a LONG_HOLD countdown runs out, so the
  // pipe fills and in_ready must fall.
  initial begin : result_sink
    int  idle_left;
    logic next_ready;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && out_ready) check_word();
        if (in_valid && !in_ready) backpressure_cycles++;
        next_ready = 1'b1;
        if (hold_request) begin
          hold_request = 1'b0;
          sink_holding = 1'b1;
          idle_left = LONG_HOLD;
        end
        if (idle_left > 0) begin
          idle_left--;
          next_ready = 1'b0;
        end else begin
          sink_holding = 1'b0;
          if (!calm && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(1, 14) - 1;
            next_ready = 1'b0;
          end
        end
        out_ready <= next_ready;
      end
    end
  end

  initial begin : stimulus
    crossing_t want;
    seg_pair_t pair;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        want.code = dir_rows[i].code;
        want.px = dir_rows[i].px;
        want.py = dir_rows[i].py;
      end else begin
        want = predict_crossing(dir_rows[i].seg);
      end
      offer_pair(dir_rows[i].seg, want);
    end

    // Random part: idling switched per block of 100, none in the last block.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      if (k >= RAND_ITEMS - 100) calm = 1'b1;
      if (k == 60) hold_request = 1'b1;
      pair = rand_pair();
      offer_pair(pair, predict_crossing(pair));
    end
    in_valid <= 1'b0;

    // Drain, then give stray words time to show up.
    while (crossings_due.size() != 0) @(posedge clk);
    repeat (NSTAGE + 8) @(posedge clk);

    $display("Sent %0d segment pairs (%0d directed), checked %0d words.",
             sent_count, DIR_ROWS, checked_count);
    $display("Outcomes: %0d hit, %0d parallel, %0d t out, %0d u out; input stalled %0d cycles.",
             outcome_seen[OUT_HIT], outcome_seen[OUT_PARALLEL],
             outcome_seen[OUT_T_OUTSIDE], outcome_seen[OUT_U_OUTSIDE],
             backpressure_cycles);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sip_pkg.sv
hw/rtl/sip_geom.sv
hw/rtl/sip_div_step.sv
hw/rtl/segment_intersection_point.sv
hw/rtl/sip_checker.sv
bench/segment_intersection_point_tb.sv
